[sv/mbrtu_pkg.sv]
package mbrtu_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 2);
    localparam int LEN_W = 9;
    localparam int CMP_W = (IDX_W > LEN_W) ? IDX_W : LEN_W;

    localparam logic [IDX_W-1:0] IDX_SAT = IDX_W'(MAX_FRAME_BYTES + 1);
    localparam logic [CMP_W-1:0] LIMIT_CAP = CMP_W'(MAX_FRAME_BYTES);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] SIL_MAX = 16'hFFFF;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
    localparam logic [7:0] BCAST_UNIT = 8'hFF;

    localparam logic [1:0] REQ_TX_BYTE = 2'd0;
    localparam logic [1:0] REQ_RX_BYTE = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_PENDING = 3'd1;
    localparam logic [2:0] EV_VALID = 3'd2;
    localparam logic [2:0] EV_INVALID = 3'd3;
    localparam logic [2:0] EV_TIMEOUT = 3'd4;
    localparam logic [2:0] EV_REQ_SENT = 3'd5;
    localparam logic [2:0] EV_BCAST_SENT = 3'd6;

    localparam logic [1:0] REG_MAX_LEN = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_ERR_ILL = 2'd2;
    localparam logic [1:0] REG_ERR_TO = 2'd3;

    localparam logic [8:0] RST_MAX_LEN = 9'd256;
    localparam logic [15:0] RST_TIMEOUT = 16'd1000;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic       is_last;
    } item_t;

    typedef struct packed {
        logic [LEN_W-1:0] max_frame_len;
        logic [15:0]      quiet_limit;
        logic [7:0]       reply_err_code;
        logic [7:0]       drop_err_code;
    } cfg_t;

    typedef struct packed {
        logic [31:0]      dropped_count;
        logic [31:0]      invalid_count;
        logic [31:0]      valid_count;
        logic [7:0]       func_code;
        logic [7:0]       unit_id;
        logic [7:0]       error_code;
        logic [LEN_W-1:0] payload_len;
        logic [15:0]      crc_out;
    } res_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == CNT_MAX) ? v : v + 32'd1;
    endfunction

endpackage

[sv/modbus_rtu_master_frame_check_top.sv]
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid/s_tready    tdata data_byte, tuser req_type, tlast is_last
// m_        out        m_tvalid/m_tready    tuser event_res, tdata result fields
// APB       in         psel/penable/pready  four configuration registers at 4*index
//
// Every transfer yields exactly one result transfer, through the input register and then the result register.
// One item is taken per cycle while the result is not stalled; the byte-wide CRC update and the state update
// sit between the input register and the result register.
// A stalled result holds the result register and, through it, the input register.
// Reset is synchronous and active low; no clearing pass is needed.
module modbus_rtu_master_frame_check_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // data_byte
    input  logic [1:0]    s_tuser,   // req_type
    input  logic          s_tlast,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [151:0]  m_tdata,   // crc_out, payload_len, error_code, unit_id, func_code,
                                     // valid_count, invalid_count, dropped_count, zero fill
    output logic [2:0]    m_tuser,   // event_res
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    mbrtu_pkg::cfg_t  cfg;
    mbrtu_pkg::item_t item;
    mbrtu_pkg::res_t  res;
    logic             item_valid;
    logic             advance;

    mbrtu_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mbrtu_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mbrtu_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tuser    (m_tuser),
        .res        (res)
    );

    assign m_tdata = {{(152 - $bits(mbrtu_pkg::res_t)){1'b0}}, res};

endmodule

[sv/mbrtu_cfg.sv]
module mbrtu_cfg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output mbrtu_pkg::cfg_t      cfg
);

    mbrtu_pkg::cfg_t cfg_reg;
    mbrtu_pkg::cfg_t cfg_next;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[3:2])
                mbrtu_pkg::REG_MAX_LEN: cfg_next.max_frame_len = pwdata[mbrtu_pkg::LEN_W-1:0];
                mbrtu_pkg::REG_TIMEOUT: cfg_next.quiet_limit = pwdata[15:0];
                mbrtu_pkg::REG_ERR_ILL: cfg_next.reply_err_code = pwdata[7:0];
                mbrtu_pkg::REG_ERR_TO:  cfg_next.drop_err_code = pwdata[7:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            mbrtu_pkg::REG_MAX_LEN: prdata = {{(32-mbrtu_pkg::LEN_W){1'b0}}, cfg_reg.max_frame_len};
            mbrtu_pkg::REG_TIMEOUT: prdata = {16'h0000, cfg_reg.quiet_limit};
            mbrtu_pkg::REG_ERR_ILL: prdata = {24'h000000, cfg_reg.reply_err_code};
            mbrtu_pkg::REG_ERR_TO:  prdata = {24'h000000, cfg_reg.drop_err_code};
            default: prdata = 32'h0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_frame_len <= mbrtu_pkg::RST_MAX_LEN;
            cfg_reg.quiet_limit <= mbrtu_pkg::RST_TIMEOUT;
            cfg_reg.reply_err_code <= 8'h00;
            cfg_reg.drop_err_code <= 8'h00;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[sv/mbrtu_in_stage.sv]
module mbrtu_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic [1:0]          s_tuser,
    input  logic                s_tlast,
    input  logic                advance,
    output logic                item_valid,
    output mbrtu_pkg::item_t    item
);

    logic             vld_reg;
    logic             vld_next;
    mbrtu_pkg::item_t item_reg;

    assign s_tready = !vld_reg || advance;
    assign vld_next = s_tready ? s_tvalid : vld_reg;
    assign item_valid = vld_reg;
    assign item = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.req_type <= s_tuser;
            item_reg.data_byte <= s_tdata;
            item_reg.is_last <= s_tlast;
        end
    end

endmodule

[sv/mbrtu_core.sv]
module mbrtu_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  mbrtu_pkg::cfg_t     cfg,
    input  logic                item_valid,
    input  mbrtu_pkg::item_t    item,
    output logic                advance,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [2:0]          m_tuser,
    output mbrtu_pkg::res_t     res
);

    localparam int IW = mbrtu_pkg::IDX_W;
    localparam int CW = mbrtu_pkg::CMP_W;

    logic [1:0]    status_reg, status_next;
    logic [7:0]    unit_reg, unit_next;
    logic [7:0]    func_reg, func_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [15:0]   crc_reg, crc_next;
    logic [15:0]   sil_reg, sil_next;
    logic [31:0]   vtot_reg, vtot_next;
    logic [31:0]   itot_reg, itot_next;
    logic [31:0]   dtot_reg, dtot_next;

    logic            out_vld_reg, out_vld_next;
    logic [2:0]      ev_reg, ev_next;
    mbrtu_pkg::res_t res_reg, res_next;

    logic            take;
    logic [IW-1:0]   idx_inc;
    logic [CW-1:0]   idx_cmp;
    logic [CW-1:0]   limit;
    logic [CW-1:0]   max_len_ext;
    logic [15:0]     crc_upd;
    logic [15:0]     sil_inc;
    logic            wrong_unit;

    assign advance = !out_vld_reg || m_tready;
    assign take = item_valid && advance;

    assign idx_inc = (idx_reg < mbrtu_pkg::IDX_SAT) ? idx_reg + IW'(1) : idx_reg;
    assign idx_cmp = CW'(idx_inc);
    assign max_len_ext = CW'(cfg.max_frame_len);
    assign limit = (max_len_ext > mbrtu_pkg::LIMIT_CAP) ? mbrtu_pkg::LIMIT_CAP : max_len_ext;
    assign crc_upd = mbrtu_pkg::crc_byte(crc_reg, item.data_byte);
    assign sil_inc = (sil_reg < mbrtu_pkg::SIL_MAX) ? sil_reg + 16'd1 : sil_reg;
    assign wrong_unit = (idx_reg == '0) && (item.data_byte != unit_reg);

    always_comb begin
        status_next = status_reg;
        unit_next = unit_reg;
        func_next = func_reg;
        idx_next = idx_reg;
        crc_next = crc_reg;
        sil_next = sil_reg;
        vtot_next = vtot_reg;
        itot_next = itot_reg;
        dtot_next = dtot_reg;
        ev_next = mbrtu_pkg::EV_NONE;
        res_next = '0;

        if (item.req_type == mbrtu_pkg::REQ_TX_BYTE && status_reg == mbrtu_pkg::ST_CLEAR) begin
            if (idx_reg == '0) begin
                unit_next = item.data_byte;
                func_next = 8'h00;
            end else if (idx_reg == IW'(1)) begin
                func_next = item.data_byte;
            end
            crc_next = crc_upd;
            idx_next = idx_inc;
            if (item.is_last) begin
                res_next.crc_out = crc_upd;
                if (unit_next == mbrtu_pkg::BCAST_UNIT) begin
                    ev_next = mbrtu_pkg::EV_BCAST_SENT;
                end else begin
                    ev_next = mbrtu_pkg::EV_REQ_SENT;
                    status_next = mbrtu_pkg::ST_WAIT;
                    sil_next = 16'h0000;
                end
                crc_next = mbrtu_pkg::CRC_INIT;
                idx_next = '0;
            end
        end else if (item.req_type == mbrtu_pkg::REQ_RX_BYTE &&
                     status_reg != mbrtu_pkg::ST_CLEAR) begin
            sil_next = 16'h0000;
            idx_next = idx_inc;
            if (idx_cmp > limit || wrong_unit) begin
                ev_next = mbrtu_pkg::EV_INVALID;
                res_next.error_code = cfg.reply_err_code;
                itot_next = mbrtu_pkg::sat_inc(itot_reg);
                status_next = mbrtu_pkg::ST_CLEAR;
                crc_next = mbrtu_pkg::CRC_INIT;
                idx_next = '0;
            end else if (crc_upd == 16'h0000) begin
                ev_next = mbrtu_pkg::EV_VALID;
                res_next.payload_len = (idx_cmp >= CW'(2)) ?
                                       mbrtu_pkg::LEN_W'(idx_cmp - CW'(2)) : '0;
                vtot_next = mbrtu_pkg::sat_inc(vtot_reg);
                status_next = mbrtu_pkg::ST_CLEAR;
                crc_next = mbrtu_pkg::CRC_INIT;
                idx_next = '0;
            end else begin
                ev_next = mbrtu_pkg::EV_PENDING;
                crc_next = crc_upd;
                status_next = mbrtu_pkg::ST_READ;
            end
        end else if (item.req_type == mbrtu_pkg::REQ_TICK &&
                     status_reg != mbrtu_pkg::ST_CLEAR) begin
            sil_next = sil_inc;
            if (sil_inc > cfg.quiet_limit) begin
                ev_next = mbrtu_pkg::EV_TIMEOUT;
                res_next.error_code = cfg.drop_err_code;
                dtot_next = mbrtu_pkg::sat_inc(dtot_reg);
                status_next = mbrtu_pkg::ST_CLEAR;
                sil_next = 16'h0000;
                crc_next = mbrtu_pkg::CRC_INIT;
                idx_next = '0;
            end
        end

        res_next.unit_id = unit_next;
        res_next.func_code = func_next;
        res_next.valid_count = vtot_next;
        res_next.invalid_count = itot_next;
        res_next.dropped_count = dtot_next;
    end

    assign out_vld_next = advance ? item_valid : out_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= mbrtu_pkg::ST_CLEAR;
            unit_reg <= 8'h00;
            func_reg <= 8'h00;
            idx_reg <= '0;
            crc_reg <= mbrtu_pkg::CRC_INIT;
            sil_reg <= 16'h0000;
            vtot_reg <= 32'h0;
            itot_reg <= 32'h0;
            dtot_reg <= 32'h0;
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
            if (take) begin
                status_reg <= status_next;
                unit_reg <= unit_next;
                func_reg <= func_next;
                idx_reg <= idx_next;
                crc_reg <= crc_next;
                sil_reg <= sil_next;
                vtot_reg <= vtot_next;
                itot_reg <= itot_next;
                dtot_reg <= dtot_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            ev_reg <= ev_next;
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser = ev_reg;
    assign res = res_reg;

endmodule

[sv/mbrtu_checker.sv]
module mbrtu_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [151:0]  m_tdata,
    input logic [2:0]    m_tuser
);

    logic out_xfer;
    assign out_xfer = m_tvalid && m_tready;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_event_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= 3'd6)
        else $error("event code out of range");

    a_crc_only_on_send: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != 3'd5 && m_tuser != 3'd6 |-> m_tdata[15:0] == 16'h0000)
        else $error("crc reported without a request end");

    a_err_only_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != 3'd3 && m_tuser != 3'd4 |-> m_tdata[32:25] == 8'h00)
        else $error("error code reported without a failure");

    a_count_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        out_xfer && $past(out_xfer) |->
            m_tdata[80:49] >= $past(m_tdata[80:49]) &&
            m_tdata[112:81] >= $past(m_tdata[112:81]) &&
            m_tdata[144:113] >= $past(m_tdata[144:113]))
        else $error("totals decreased");

endmodule

bind modbus_rtu_master_frame_check_top mbrtu_checker u_mbrtu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
